[src/mm3_pkg.sv]
// ============================================================================
// mm3_pkg
// Shared types, constants and helper functions for the MurmurHash3 x86_32
// word-stream hasher: mix constants, controller states and datapath commands.
// ============================================================================
package mm3_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    // How the latched word enters the running hash.
    typedef enum logic [1:0] {
        MODE_FULL,
        MODE_TAIL,
        MODE_NONE
    } t_mode;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_COMB,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT
    } t_state;

    // Datapath operations, one per cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_MIX1,
        OP_MIX2,
        OP_COMB,
        OP_FIN1,
        OP_FIN2,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic key_last;   // word in flight is the final word of its key
        logic out_free;   // output register can take a result this cycle
    } t_dp_stat;

    function automatic logic [31:0] rotl15(input logic [31:0] x);
        rotl15 = {x[16:0], x[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] x);
        rotl13 = {x[18:0], x[31:19]};
    endfunction

endpackage

[src/murmur3_32_hash_stream.sv]
// ============================================================================
// murmur3_32_hash_stream
// Streaming MurmurHash3 x86_32 over a key given as little-endian words.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per transfer:
//   i_data_word (first key byte in bits 7:0), i_byte_count and i_last_word.
//   Words before the last are always hashed as full four-byte words. A last
//   word with 1..3 bytes takes the tail mix, with 0 bytes adds nothing, with
//   4 or more the full block mix.
//   The seed is written through i_cfg_wr_en / i_cfg_wr_data. A key starts
//   from the seed as it stands when its first word is taken.
//   Output channel (o_out_valid / i_out_stall) gives one 64-bit word per
//   key: seed in 63:32, finalized hash in 31:0.
// Sequence:
//   One word is worked on at a time; the mix and finalizer products share a
//   single 32x32 multiplier. A non-final word goes through accept, two
//   multiplies and the fold. A final word goes through the same steps, then
//   two finalizer multiplies and the hand-off into the output register; the
//   result is visible the cycle after.
// Reset (synchronous, active low): seed clears to 0, no key in progress, no
//   result pending.
// Stall: a result waits in the output register; the next key is accepted
//   and hashed meanwhile, and only its own hand-off waits for the register.
// ============================================================================
module murmur3_32_hash_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_result
);
    import mm3_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    mm3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // hash datapath and output register
    mm3_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last_word   (i_last_word),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_hash_result (o_hash_result),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat)
    );

endmodule

[src/mm3_ctrl.sv]
// ============================================================================
// mm3_ctrl
// Sequencer for the hasher: walks each word through the mix steps and, on a
// final word, through the finalizer and result hand-off.
// ============================================================================
module mm3_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mm3_pkg::t_dp_stat i_stat,
    output mm3_pkg::t_dp_cmd  o_cmd
);
    import mm3_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_HOLD;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MIX1;
                end
            end
            ST_MIX1: begin
                o_cmd.op = OP_MIX1;
                n_state  = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.op = OP_MIX2;
                n_state  = ST_COMB;
            end
            ST_COMB: begin
                o_cmd.op = OP_COMB;
                n_state  = i_stat.key_last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                o_cmd.op = OP_FIN1;
                n_state  = ST_FIN2;
            end
            ST_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                // wait for the output register to drain
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[src/mm3_datapath.sv]
// ============================================================================
// mm3_datapath
// Hash datapath: one shared 32x32 multiplier, the running hash and byte
// total, the seed register and the output register.
// ============================================================================
module mm3_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,
    input  logic [31:0]       i_data_word,
    input  logic [2:0]        i_byte_count,
    input  logic              i_last_word,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [63:0]       o_hash_result,
    input  mm3_pkg::t_dp_cmd  i_cmd,
    output mm3_pkg::t_dp_stat o_stat
);
    import mm3_pkg::*;

    logic [31:0] r_seed;
    logic        r_key_active;
    logic [31:0] r_acc;
    logic [31:0] r_total;
    logic [31:0] r_word;
    t_mode       r_mode;
    logic        r_last;
    logic [31:0] r_seed_out;
    logic [31:0] r_prod;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    t_mode       mode_in;
    logic [31:0] word_in;
    logic [2:0]  inc_in;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic [31:0] fin_x;
    logic [31:0] comb_h;

    // input word classification
    always_comb begin
        mode_in = MODE_FULL;
        inc_in  = 3'd4;
        word_in = i_data_word;
        if (i_last_word && !i_byte_count[2]) begin
            unique case (i_byte_count[1:0])
                2'd0: begin
                    mode_in = MODE_NONE;
                    inc_in  = 3'd0;
                    word_in = '0;
                end
                2'd1: begin
                    mode_in = MODE_TAIL;
                    inc_in  = 3'd1;
                    word_in = {24'd0, i_data_word[7:0]};
                end
                2'd2: begin
                    mode_in = MODE_TAIL;
                    inc_in  = 3'd2;
                    word_in = {16'd0, i_data_word[15:0]};
                end
                default: begin
                    mode_in = MODE_TAIL;
                    inc_in  = 3'd3;
                    word_in = {8'd0, i_data_word[23:0]};
                end
            endcase
        end
    end

    assign fin_x = r_acc ^ r_total;

    // shared multiplier operand select
    always_comb begin
        mul_a = r_word;
        mul_b = MIX_C1;
        unique case (i_cmd.op)
            OP_MIX2: begin
                mul_a = rotl15(r_prod);
                mul_b = MIX_C2;
            end
            OP_FIN1: begin
                mul_a = fin_x ^ {16'd0, fin_x[31:16]};
                mul_b = FIN_M1;
            end
            OP_FIN2: begin
                mul_a = r_prod ^ {13'd0, r_prod[31:13]};
                mul_b = FIN_M2;
            end
            default: begin
                mul_a = r_word;
                mul_b = MIX_C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // fold the scrambled word into the hash
    always_comb begin
        unique case (r_mode)
            MODE_FULL: comb_h = (rotl13(r_acc ^ r_prod) * 32'd5) + MIX_ADD;
            MODE_TAIL: comb_h = r_acc ^ r_prod;
            default:   comb_h = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= '0;
            r_key_active <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
            if (i_cmd.op == OP_LOAD) begin
                r_key_active <= !i_last_word;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_acc      <= r_key_active ? r_acc : r_seed;
                r_total    <= (r_key_active ? r_total : 32'd0) + {29'd0, inc_in};
                r_word     <= word_in;
                r_mode     <= mode_in;
                r_last     <= i_last_word;
                r_seed_out <= r_seed;
            end
            OP_MIX1, OP_MIX2, OP_FIN1, OP_FIN2: begin
                r_prod <= mul_p;
            end
            OP_COMB: begin
                r_acc <= comb_h;
            end
            OP_EMIT: begin
                r_out_data <= {r_seed_out, r_prod ^ {16'd0, r_prod[31:16]}};
            end
            default: begin
            end
        endcase
    end

    assign o_stat.key_last = r_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_hash_result   = r_out_data;

endmodule

[src/mm3_checker.sv]
// ============================================================================
// mm3_checker
// Port-level checks for the hasher, bound onto the top level.
// ============================================================================
module mm3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_hash_result
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hash_result)))
        else $error("result changed or dropped while stalled");

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("word accepted while previous word in work");

    // a new result is only produced out of the busy hand-off step
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work in progress");

    // reset leaves the block empty and ready
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after reset");

endmodule

bind murmur3_32_hash_stream mm3_checker u_mm3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_hash_result (o_hash_result)
);

[tb/sv/tb_murmur3_32_hash_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur3_32_hash_stream
// Self-checking bench for the streaming MurmurHash3 x86_32 hasher. Keys go in
// one word per handshake, and a local predictor tracks the running hash, the
// byte total and the seed. Each accepted result is compared with the oldest
// predicted hash. Directed keys cover the byte-count and seed corner cases.
// Random keys then run under three sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_murmur3_32_hash_stream;
    import mm3_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    // Margin for a word still in the hasher to reach the output register; padded.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_WORDS   = 145;

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [31:0] data_word   = '0;
    logic [2:0]  byte_count  = '0;
    logic        last_word   = 1'b0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [63:0] hash_result;

    murmur3_32_hash_stream u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_data_word   (data_word),
        .i_byte_count  (byte_count),
        .i_last_word   (last_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_hash_result (hash_result)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a mirror of what the hasher keeps per key
    // ------------------------------------------------------------------
    logic [31:0] seed_reg  = '0;    // seed register as last written
    logic [31:0] run_hash  = '0;    // running hash between words of a key
    logic [31:0] key_bytes = '0;    // bytes hashed so far, wraps at 2^32
    logic        key_open  = 1'b0;  // a key has taken at least one word

    logic [63:0] expected_hashes[$];

    int snd_idle_pct = 0;   // chance in 100 the sender holds off a cycle
    int rcv_idle_pct = 0;   // chance in 100 the receiver stalls a cycle
    int words_sent   = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    // Word scramble: multiply, rotate left 15, multiply.
    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = {t[16:0], t[31:17]};
        return t * MIX_C2;
    endfunction

    // fmix32 avalanche on the closed-out hash.
    function automatic logic [31:0] finalize_hash(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_M1;
        t = t ^ (t >> 13);
        t = t * FIN_M2;
        return t ^ (t >> 16);
    endfunction

    // Fold one accepted word into the predicted state; on the last word of a
    // key, queue the expected 64-bit result and rearm for the next key.
    function automatic void hash_word(input logic [31:0] word, input logic [2:0] count,
                                      input logic last);
        logic [31:0] h;
        logic [31:0] mask;
        // A fresh key starts from the seed register as it is right now.
        h = key_open ? run_hash : seed_reg;
        if (!last || count >= 3'd4) begin
            // Non-final words are always full words; final counts 5..7 act as 4.
            h = h ^ scramble_word(word);
            h = {h[18:0], h[31:19]};
            h = h * 32'd5 + MIX_ADD;
            key_bytes = key_bytes + 32'd4;
        end else if (count != 3'd0) begin
            // Tail mix: bytes above the count are dropped, no rotate/add.
            case (count)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                default: mask = 32'h00ff_ffff;
            endcase
            h = h ^ scramble_word(word & mask);
            key_bytes = key_bytes + {29'd0, count};
        end
        if (!last) begin
            run_hash = h;
            key_open = 1'b1;
        end else begin
            h = finalize_hash(h ^ key_bytes);
            // Upper half shows the seed as it stands at the last word.
            expected_hashes.push_back({seed_reg, h});
            run_hash  = seed_reg;
            key_bytes = '0;
            key_open  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one word per call, random hold-off before raising valid
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                             input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= word;
        byte_count <= count;
        last_word  <= last;
        @(posedge clk);
        // Payload holds while stalled; the word goes at the first unstalled edge.
        while (in_stall) @(posedge clk);
        hash_word(word, count, last);
        words_sent++;
    endtask

    // Drop valid, wait for every queued result, then let the hasher finish
    // any non-final word still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        seed_reg = value;
        if (!key_open)
            run_hash = value;
    endtask

    // Mostly random words, with the all-zero and all-one patterns mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One whole key: mostly short, now and then a long one. Non-final words
    // mostly carry 4 but sometimes a stray count that must be ignored.
    task automatic send_random_key();
        int          n_words;
        logic [2:0]  cnt;
        n_words = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
        for (int i = 0; i < n_words - 1; i++) begin
            cnt = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'd4;
            send_word(pick_word(), cnt, 1'b0);
        end
        send_word(pick_word(), 3'($urandom_range(7)), 1'b1);
    endtask

    task automatic run_random_phase(input int snd_pct, input int rcv_pct,
                                    input logic [31:0] seed);
        int start_words;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        write_seed(seed);
        start_words = words_sent;
        while (words_sent - start_words < PHASE_WORDS) begin
            send_random_key();
            // Occasional reseed or full drain between keys.
            case ($urandom_range(19))
                0:       write_seed($urandom);
                1:       wait_idle();
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Seed still at its reset value; includes an empty key.
    task automatic test_reset_seed();
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd0, 1'b1);
    endtask

    // Single-word keys with every final byte count, 0 through 7.
    task automatic test_final_counts();
        write_seed(32'hffff_ffff);
        for (int c = 0; c < 8; c++)
            send_word((c % 2) ? 32'hffff_ffff : 32'ha5c3_e17b, 3'(c), 1'b1);
    endtask

    // Non-final words with odd counts are still hashed as full words.
    task automatic test_nonfinal_counts();
        write_seed(32'h9747_b28c);
        send_word(32'hffff_ffff, 3'd0, 1'b0);
        send_word(32'h0000_0000, 3'd3, 1'b0);
        send_word(32'h1234_5678, 3'd7, 1'b0);
        send_word(32'h8000_0001, 3'd4, 1'b0);
        send_word(32'hdead_beef, 3'd1, 1'b1);
    endtask

    // Seed rewritten inside a key: hash keeps the old seed, upper half the new.
    task automatic test_seed_mid_key();
        write_seed(32'h0123_4567);
        send_word(32'hcafe_f00d, 3'd4, 1'b0);
        send_word(32'h7fff_ffff, 3'd4, 1'b0);
        write_seed(32'h0000_0000);
        send_word(32'hfeed_face, 3'd2, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random tests, one per stall mix
    // ------------------------------------------------------------------
    task automatic test_slow_receiver();
        run_random_phase(8, 58, 32'hffff_ffff);
    endtask

    task automatic test_slow_sender();
        run_random_phase(58, 8, $urandom);
    endtask

    task automatic test_full_rate();
        run_random_phase(0, 0, 32'h0000_0000);
    endtask

    // ------------------------------------------------------------------
    // Receiver stall, result checker and run limit
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rcv_idle_pct);

    always @(posedge clk) begin : check_results
        logic [63:0] want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_hashes.size() == 0) begin
                $error("hash_result: no result expected, got %h", hash_result);
                error_count++;
            end else begin
                want = expected_hashes.pop_front();
                if (hash_result !== want) begin
                    $error("hash_result: expected %h, got %h", want, hash_result);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        snd_idle_pct = 8;
        rcv_idle_pct = 58;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_seed();
        test_final_counts();
        test_nonfinal_counts();
        test_seed_mid_key();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();

        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[murmur3_32_hash_stream.f]
src/mm3_pkg.sv
src/mm3_ctrl.sv
src/mm3_datapath.sv
src/murmur3_32_hash_stream.sv
src/mm3_checker.sv
tb/sv/tb_murmur3_32_hash_stream.sv
